// ----- hdl/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, pipeline stage indexes and types for the segment distance
// pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int COORD_W = 24;              // Q8.16 coordinate
    localparam int VEC_W   = COORD_W + 1;     // difference vectors, Q9.16
    localparam int PROD_W  = 2 * VEC_W;       // one term of a dot product
    localparam int COEF_W  = PROD_W + 2;      // sum of three terms
    localparam int Q_W     = 17;              // Q1.16 in [0, 1]
    localparam int FRAC_W  = 16;
    localparam int DIST_W  = 25;              // Q9.16 result

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;

    // divider operand widths
    localparam int SDIV_W = COEF_W + 1;               // -c, b-c over a
    localparam int GDIV_W = 2 * COEF_W + 2;           // general s quotient
    localparam int BS_W   = COEF_W + Q_W + 1;         // b * s
    localparam int TDIV_W = BS_W + 2;                 // t quotient

    // closest point difference and its squared length
    localparam int COMP_W = VEC_W + Q_W + 3;
    localparam int SQ_W   = 2 * COMP_W + 2;
    localparam int RAD_W  = SQ_W - 32;
    localparam int SQRT_STEPS = RAD_W / 2;

    // latencies of the sub units (register stages)
    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = FRAC_W + 1;

    // pipeline register indexes
    localparam int P_GEO    = 1;
    localparam int P_COEF   = 3;
    localparam int P_DIV1   = P_COEF + MUL_LAT + 1;
    localparam int P_SEL    = P_DIV1 + DIV_LAT;
    localparam int P_BS     = P_SEL + MUL_LAT;
    localparam int P_TN     = P_BS + 1;
    localparam int P_TSEL   = P_TN + DIV_LAT;
    localparam int P_ST     = P_TSEL + 1;
    localparam int P_PROD   = P_ST + 1;
    localparam int P_COMP   = P_PROD + 1;
    localparam int P_SQMUL  = P_COMP + MUL_LAT;
    localparam int P_SQ     = P_SQMUL + 1;
    localparam int LAT      = P_SQ + SQRT_STEPS;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] d1;
        logic [2:0][VEC_W-1:0] d2;
        logic [2:0][VEC_W-1:0] r;
    } geo_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] e;
        logic signed [COEF_W-1:0] f;
    } coef_t;

    typedef struct packed {
        logic [Q_W-1:0] sg;
        logic [Q_W-1:0] s0;
        logic [Q_W-1:0] s1;
        logic           az;
        logic           ez;
    } sel_t;

    typedef struct packed {
        logic tneg;
        logic tgt;
    } tflag_t;

endpackage

// ----- hdl/ssd_mul.sv -----
// ----------------------------------------------------------------------------
// ssd_mul
// Two stage signed multiplier: four partial products, then their sum.
// ----------------------------------------------------------------------------
module ssd_mul #(
    parameter int WA = 52,
    parameter int WB = 52
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    localparam int HA = WA / 2;
    localparam int HB = WB / 2;
    localparam int WP = WA + WB;

    logic signed [WA-HA+WB-HB-1:0] hh_reg, hh_next;
    logic signed [WA-HA+HB:0]      hl_reg, hl_next;
    logic signed [HA+WB-HB:0]      lh_reg, lh_next;
    logic        [HA+HB-1:0]       ll_reg, ll_next;
    logic signed [WP-1:0]          p_reg, p_next;

    // upper halves carry the sign, lower halves are magnitudes
    always_comb
    begin
        hh_next = $signed(a[WA-1:HA]) * $signed(b[WB-1:HB]);
        hl_next = $signed(a[WA-1:HA]) * $signed({1'b0, b[HB-1:0]});
        lh_next = $signed({1'b0, a[HA-1:0]}) * $signed(b[WB-1:HB]);
        ll_next = a[HA-1:0] * b[HB-1:0];
        p_next  = (WP'(hh_reg) <<< (HA + HB)) + (WP'(hl_reg) <<< HA)
                + (WP'(lh_reg) <<< HB) + $signed(WP'(ll_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- hdl/ssd_div.sv -----
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined clamped quotient n/d in Q1.16: 0 for n <= 0, 1.0 for n >= d,
// else one restoring step per stage.
// ----------------------------------------------------------------------------
module ssd_div #(
    parameter int W = 53
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [W-1:0]         n,
    input  logic signed [W-1:0]         d,
    output logic [ssd_pkg::Q_W-1:0]     q
);
    import ssd_pkg::*;

    logic [W-1:0]      rem_reg  [0:FRAC_W];
    logic [W-1:0]      rem_next [0:FRAC_W];
    logic [W-1:0]      d_reg    [0:FRAC_W];
    logic [FRAC_W-1:0] q_reg    [0:FRAC_W];
    logic [FRAC_W-1:0] q_next   [0:FRAC_W];
    logic              zero_reg [0:FRAC_W];
    logic              one_reg  [0:FRAC_W];
    logic [W:0]        rem2;
    logic [W:0]        dd;

    always_comb
    begin
        rem_next[0] = n;
        q_next[0]   = '0;
        rem2        = '0;
        dd          = '0;
        for (int i = 1; i <= FRAC_W; i++)
        begin
            rem2 = {rem_reg[i-1], 1'b0};
            dd   = {1'b0, d_reg[i-1]};
            if (rem2 >= dd)
            begin
                rem_next[i] = W'(rem2 - dd);
                q_next[i]   = {q_reg[i-1][FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem2[W-1:0];
                q_next[i]   = {q_reg[i-1][FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            d_reg[0]    <= d;
            zero_reg[0] <= (n <= 0);
            one_reg[0]  <= (n >= d);
            for (int i = 1; i <= FRAC_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                q_reg[i]    <= q_next[i];
                d_reg[i]    <= d_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                one_reg[i]  <= one_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[FRAC_W])
            q = '0;
        else if (one_reg[FRAC_W])
            q = ONE_Q;
        else
            q = {1'b0, q_reg[FRAC_W]};
    end

endmodule

// ----- hdl/segment_segment_distance.sv -----
// ----------------------------------------------------------------------------
// segment_segment_distance
// Shortest distance between two 3D segments, Q8.16 in, Q9.16 out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | request   | in_valid / in_stall  | seg1_*, seg2_* (12 x 24 bit)
//  out     | result    | out_valid / out_stall| min_distance (25 bit)
//
// One request per cycle unless the pipeline is stalled; the depth is set mainly by the two quotient
// pipelines (17 stages each) and the 30 stage square root.
// Reset clears only the valid bits of the pipeline.
// A held result stalls the whole pipeline; nothing moves until it is taken.
// ----------------------------------------------------------------------------
module segment_segment_distance (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg1_start_x,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg1_start_y,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg1_start_z,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg1_end_x,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg1_end_y,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg1_end_z,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg2_start_x,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg2_start_y,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg2_start_z,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg2_end_x,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg2_end_y,
    input  logic signed [ssd_pkg::COORD_W-1:0]  seg2_end_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ssd_pkg::DIST_W-1:0]          min_distance
);
    import ssd_pkg::*;

    logic en;
    logic vld_reg [1:LAT];

    logic signed [COORD_W-1:0] p1 [3];
    logic signed [COORD_W-1:0] q1 [3];
    logic signed [COORD_W-1:0] p2 [3];
    logic signed [COORD_W-1:0] q2 [3];

    geo_t  geo_next;
    geo_t  geo_reg [P_GEO:P_PROD];

    logic signed [PROD_W-1:0] pa_reg [3], pe_reg [3], pb_reg [3], pc_reg [3], pf_reg [3];
    logic signed [PROD_W-1:0] pa_next [3], pe_next [3], pb_next [3], pc_next [3], pf_next [3];

    coef_t coef_next;
    coef_t coef_reg [P_COEF:P_BS];

    logic signed [2*COEF_W-1:0] ae, bb, bf, ce;
    logic signed [GDIV_W-1:0]   num_reg, den_reg, num_next, den_next;
    logic signed [SDIV_W-1:0]   n0_reg, n1_reg, da_reg, n0_next, n1_next;
    logic                       dz_reg [P_DIV1:P_SEL];

    logic [Q_W-1:0] sg_q, s0_q, s1_q, t_q, sg_gate;
    sel_t           sel_next;
    sel_t           sel_reg [P_SEL+1:P_TSEL];

    logic signed [BS_W-1:0]     bs;
    logic signed [TDIV_W-1:0]   tn_reg, td_reg, tn_next, td_next;
    tflag_t                     tf_next;
    tflag_t                     tf_reg [P_TN+1:P_TSEL];

    logic [Q_W-1:0] s_reg, t_reg, s_next, t_next;

    logic signed [VEC_W+Q_W:0]  pd1_reg [3], pd2_reg [3], pd1_next [3], pd2_next [3];
    logic signed [COMP_W-1:0]   comp_reg [3], comp_next [3];
    logic signed [2*COMP_W-1:0] csq [3];
    logic signed [SQ_W-1:0]     sq;

    logic [RAD_W-1:0] rn_reg [0:SQRT_STEPS], rn_next [0:SQRT_STEPS];
    logic [RAD_W-1:0] rr_reg [0:SQRT_STEPS], rr_next [0:SQRT_STEPS];
    logic [RAD_W:0]   trial;
    logic [RAD_W-1:0] bitv;

    assign out_valid = vld_reg[LAT];
    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- direction vectors and dot products ----------------
    assign p1 = '{seg1_start_x, seg1_start_y, seg1_start_z};
    assign q1 = '{seg1_end_x, seg1_end_y, seg1_end_z};
    assign p2 = '{seg2_start_x, seg2_start_y, seg2_start_z};
    assign q2 = '{seg2_end_x, seg2_end_y, seg2_end_z};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geo_next.d1[k] = VEC_W'(q1[k]) - VEC_W'(p1[k]);
            geo_next.d2[k] = VEC_W'(q2[k]) - VEC_W'(p2[k]);
            geo_next.r[k]  = VEC_W'(p1[k]) - VEC_W'(p2[k]);
            pa_next[k] = $signed(geo_reg[P_GEO].d1[k]) * $signed(geo_reg[P_GEO].d1[k]);
            pe_next[k] = $signed(geo_reg[P_GEO].d2[k]) * $signed(geo_reg[P_GEO].d2[k]);
            pb_next[k] = $signed(geo_reg[P_GEO].d1[k]) * $signed(geo_reg[P_GEO].d2[k]);
            pc_next[k] = $signed(geo_reg[P_GEO].d1[k]) * $signed(geo_reg[P_GEO].r[k]);
            pf_next[k] = $signed(geo_reg[P_GEO].d2[k]) * $signed(geo_reg[P_GEO].r[k]);
        end
        coef_next.a = COEF_W'(pa_reg[0]) + COEF_W'(pa_reg[1]) + COEF_W'(pa_reg[2]);
        coef_next.e = COEF_W'(pe_reg[0]) + COEF_W'(pe_reg[1]) + COEF_W'(pe_reg[2]);
        coef_next.b = COEF_W'(pb_reg[0]) + COEF_W'(pb_reg[1]) + COEF_W'(pb_reg[2]);
        coef_next.c = COEF_W'(pc_reg[0]) + COEF_W'(pc_reg[1]) + COEF_W'(pc_reg[2]);
        coef_next.f = COEF_W'(pf_reg[0]) + COEF_W'(pf_reg[1]) + COEF_W'(pf_reg[2]);
    end

    // ---------------- cross products for the general quotient ----------------
    ssd_mul #(.WA(COEF_W), .WB(COEF_W)) u_mul_ae (
        .clk(clk), .en(en), .a(coef_reg[P_COEF].a), .b(coef_reg[P_COEF].e), .p(ae));
    ssd_mul #(.WA(COEF_W), .WB(COEF_W)) u_mul_bb (
        .clk(clk), .en(en), .a(coef_reg[P_COEF].b), .b(coef_reg[P_COEF].b), .p(bb));
    ssd_mul #(.WA(COEF_W), .WB(COEF_W)) u_mul_bf (
        .clk(clk), .en(en), .a(coef_reg[P_COEF].b), .b(coef_reg[P_COEF].f), .p(bf));
    ssd_mul #(.WA(COEF_W), .WB(COEF_W)) u_mul_ce (
        .clk(clk), .en(en), .a(coef_reg[P_COEF].c), .b(coef_reg[P_COEF].e), .p(ce));

    always_comb
    begin
        den_next = GDIV_W'(ae) - GDIV_W'(bb);
        num_next = GDIV_W'(bf) - GDIV_W'(ce);
        n0_next  = -SDIV_W'(coef_reg[P_DIV1-1].c);
        n1_next  = SDIV_W'(coef_reg[P_DIV1-1].b) - SDIV_W'(coef_reg[P_DIV1-1].c);
    end

    // ---------------- three s quotients in parallel ----------------
    ssd_div #(.W(GDIV_W)) u_div_sg (
        .clk(clk), .en(en), .n(num_reg), .d(den_reg), .q(sg_q));
    ssd_div #(.W(SDIV_W)) u_div_s0 (
        .clk(clk), .en(en), .n(n0_reg), .d(da_reg), .q(s0_q));
    ssd_div #(.W(SDIV_W)) u_div_s1 (
        .clk(clk), .en(en), .n(n1_reg), .d(da_reg), .q(s1_q));

    // parallel (or first degenerate) forces s = 0 before the t step
    assign sg_gate = dz_reg[P_SEL] ? '0 : sg_q;

    always_comb
    begin
        sel_next.sg = sg_gate;
        sel_next.s0 = s0_q;
        sel_next.s1 = s1_q;
        sel_next.az = (coef_reg[P_SEL].a == '0);
        sel_next.ez = (coef_reg[P_SEL].e == '0);
    end

    ssd_mul #(.WA(COEF_W), .WB(Q_W+1)) u_mul_bs (
        .clk(clk), .en(en), .a(coef_reg[P_SEL].b), .b($signed({1'b0, sg_gate})), .p(bs));

    always_comb
    begin
        tn_next = TDIV_W'(bs) + (TDIV_W'(coef_reg[P_BS].f) <<< FRAC_W);
        td_next = TDIV_W'(coef_reg[P_BS].e) <<< FRAC_W;
        tf_next.tneg = tn_reg < 0;
        tf_next.tgt  = tn_reg > td_reg;
    end

    ssd_div #(.W(TDIV_W)) u_div_t (
        .clk(clk), .en(en), .n(tn_reg), .d(td_reg), .q(t_q));

    // ---------------- final s, t choice ----------------
    always_comb
    begin
        s_next = sel_reg[P_TSEL].sg;
        t_next = t_q;
        if (sel_reg[P_TSEL].az && sel_reg[P_TSEL].ez)
        begin
            s_next = '0;
            t_next = '0;
        end
        else if (sel_reg[P_TSEL].az)
        begin
            s_next = '0;
        end
        else if (sel_reg[P_TSEL].ez)
        begin
            s_next = sel_reg[P_TSEL].s0;
            t_next = '0;
        end
        else if (tf_reg[P_TSEL].tneg)
        begin
            s_next = sel_reg[P_TSEL].s0;
            t_next = '0;
        end
        else if (tf_reg[P_TSEL].tgt)
        begin
            s_next = sel_reg[P_TSEL].s1;
            t_next = ONE_Q;
        end
    end

    // ---------------- closest point difference ----------------
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd1_next[k] = $signed(geo_reg[P_ST].d1[k]) * $signed({1'b0, s_reg});
            pd2_next[k] = $signed(geo_reg[P_ST].d2[k]) * $signed({1'b0, t_reg});
            comp_next[k] = (COMP_W'($signed(geo_reg[P_PROD].r[k])) <<< FRAC_W)
                         + COMP_W'(pd1_reg[k]) - COMP_W'(pd2_reg[k]);
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_sq
        ssd_mul #(.WA(COMP_W), .WB(COMP_W)) u_mul_sq (
            .clk(clk), .en(en), .a(comp_reg[k]), .b(comp_reg[k]), .p(csq[k]));
    end

    assign sq = SQ_W'(csq[0]) + SQ_W'(csq[1]) + SQ_W'(csq[2]);

    // ---------------- square root, one result bit per stage ----------------
    always_comb
    begin
        rn_next[0] = sq[SQ_W-1:32];
        rr_next[0] = '0;
        trial      = '0;
        bitv       = '0;
        for (int j = 1; j <= SQRT_STEPS; j++)
        begin
            bitv  = RAD_W'(1) << (2 * (SQRT_STEPS - j));
            trial = {1'b0, rr_reg[j-1]} + {1'b0, bitv};
            if ({1'b0, rn_reg[j-1]} >= trial)
            begin
                rn_next[j] = RAD_W'({1'b0, rn_reg[j-1]} - trial);
                rr_next[j] = (rr_reg[j-1] >> 1) + bitv;
            end
            else
            begin
                rn_next[j] = rn_reg[j-1];
                rr_next[j] = rr_reg[j-1] >> 1;
            end
        end
    end

    assign min_distance = rr_reg[SQRT_STEPS][DIST_W-1:0];

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[P_GEO] <= geo_next;
            for (int i = P_GEO + 1; i <= P_PROD; i++)
                geo_reg[i] <= geo_reg[i-1];
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k]   <= pa_next[k];
                pe_reg[k]   <= pe_next[k];
                pb_reg[k]   <= pb_next[k];
                pc_reg[k]   <= pc_next[k];
                pf_reg[k]   <= pf_next[k];
                pd1_reg[k]  <= pd1_next[k];
                pd2_reg[k]  <= pd2_next[k];
                comp_reg[k] <= comp_next[k];
            end
            coef_reg[P_COEF] <= coef_next;
            for (int i = P_COEF + 1; i <= P_BS; i++)
                coef_reg[i] <= coef_reg[i-1];
            num_reg <= num_next;
            den_reg <= den_next;
            n0_reg  <= n0_next;
            n1_reg  <= n1_next;
            da_reg  <= SDIV_W'(coef_reg[P_DIV1-1].a);
            dz_reg[P_DIV1] <= (den_next == '0);
            for (int i = P_DIV1 + 1; i <= P_SEL; i++)
                dz_reg[i] <= dz_reg[i-1];
            sel_reg[P_SEL+1] <= sel_next;
            for (int i = P_SEL + 2; i <= P_TSEL; i++)
                sel_reg[i] <= sel_reg[i-1];
            tn_reg <= tn_next;
            td_reg <= td_next;
            tf_reg[P_TN+1] <= tf_next;
            for (int i = P_TN + 2; i <= P_TSEL; i++)
                tf_reg[i] <= tf_reg[i-1];
            s_reg <= s_next;
            t_reg <= t_next;
            for (int j = 0; j <= SQRT_STEPS; j++)
            begin
                rn_reg[j] <= rn_next[j];
                rr_reg[j] <= rr_next[j];
            end
        end
    end

endmodule
